>>> rtl/clsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_pkg - shared types and constants for the collatz step counter
// Holds the controller states, the command and status groups between the
// controller and the datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package clsc_pkg;

	// fixed field widths
	localparam int unsigned START_W = 64;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TOTAL_W = 64;

	// saturation level of the per-item step count
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // take a new item into the working registers
		logic step;    // apply one shortcut map step
		logic finish;  // form the result and update the running total
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic done;    // value is one or less, or an overflow was seen
	} dp_stat_t;

endpackage

>>> rtl/clsc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_dp - collatz datapath
// Working value, step counter, overflow flag, running total and the result
// payload registers. Moves one shortcut step per step command.
// ----------------------------------------------------------------------------
module clsc_dp #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  clsc_pkg::dp_cmd_t               cmd,
	output clsc_pkg::dp_stat_t              stat,
	input  logic [clsc_pkg::START_W-1:0]    start_number,
	input  logic                            restart_total,
	output logic [clsc_pkg::COUNT_W-1:0]    step_count,
	output logic [clsc_pkg::TOTAL_W-1:0]    total_steps,
	output logic                            overflow
);
	import clsc_pkg::*;

	logic [VALUE_WIDTH-1:0] t_q;
	logic [VALUE_WIDTH-1:0] half;
	logic [VALUE_WIDTH-1:0] t_next_odd;
	logic                   odd_ovf;
	logic [COUNT_W-1:0]     cnt_q;
	logic [COUNT_W:0]       cnt_sum;
	logic [COUNT_W-1:0]     cnt_next;
	logic                   ovf_q;
	logic                   restart_q;
	logic [COUNT_W-1:0]     reported;
	logic [TOTAL_W-1:0]     total_q;
	logic [TOTAL_W-1:0]     total_base;
	logic [COUNT_W-1:0]     step_count_q;
	logic                   overflow_q;

	// odd step: (3t+1)/2 = half + t + 1, too wide when half >= max - t
	assign half       = t_q >> 1;
	assign odd_ovf    = half >= ~t_q;
	assign t_next_odd = half + t_q + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

	// saturating step count, two steps for an odd value
	assign cnt_sum  = {1'b0, cnt_q} + (t_q[0] ? (COUNT_W+1)'(2) : (COUNT_W+1)'(1));
	assign cnt_next = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];

	// finished when the value is one or less, or on overflow
	assign stat.done = (t_q[VALUE_WIDTH-1:1] == '0) || ovf_q;

	// result values
	assign reported   = ovf_q ? '0 : cnt_q;
	assign total_base = restart_q ? '0 : total_q;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q       <= start_number[VALUE_WIDTH-1:0];
			cnt_q     <= '0;
			restart_q <= restart_total;
		end else if (cmd.step) begin
			if (!t_q[0]) begin
				t_q   <= half;
				cnt_q <= cnt_next;
			end else if (!odd_ovf) begin
				t_q   <= t_next_odd;
				cnt_q <= cnt_next;
			end
		end
	end

	// overflow flag for the item at work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			ovf_q <= 1'b0;
		end else if (cmd.step && t_q[0] && odd_ovf) begin
			ovf_q <= 1'b1;
		end
	end

	// running total, kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.finish) begin
			total_q <= total_base + {{(TOTAL_W-COUNT_W){1'b0}}, reported};
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			step_count_q <= reported;
			overflow_q   <= ovf_q;
		end
	end

	assign step_count  = step_count_q;
	assign total_steps = total_q;
	assign overflow    = overflow_q;

	// an even value halves on a step
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cmd.load && !t_q[0]) |=> (t_q == $past(half)))
		else $error("even step did not halve the value");

	// an overflowed item stops counting
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && !cmd.load) |=> $stable(cnt_q))
		else $error("step count moved after overflow");

endmodule

>>> rtl/clsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_ctrl - collatz controller
// Sequences load, step and finish for one item at a time and owns the
// handshake control of both channels, including the result valid flag.
// ----------------------------------------------------------------------------
module clsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output clsc_pkg::dp_cmd_t    cmd,
	input  clsc_pkg::dp_stat_t   stat
);
	import clsc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        rsp_valid_q;
	logic        out_free;

	// result register can take a new item
	assign out_free = !rsp_valid_q || !rsp_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!stat.done) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// commands are exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.finish}))
		else $error("more than one datapath command at once");

	// a finished item waiting on a full result register is held
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && stat.done && !out_free) |=> (state_q == ST_HOLD))
		else $error("finished item not held for the result register");

endmodule

>>> rtl/collatz_step_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collatz_step_counter - shortcut collatz step counter with running total
// Counts the collatz steps of each starting number down to one, adds
// the count to a running total and flags values that grow too wide.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   req     | req_valid / req_stall | start_number, restart_total
//   rsp     | rsp_valid / rsp_stall | step_count, total_steps, overflow
//
// An item takes a load command, one step command per shortcut map step in the
// datapath (plus one that detects an overflow) and a finish command; a stalled
// result adds a hold state before the finish. There is a single step unit.
// Reset clears the running total, controller state and result valid.
// req_stall is high while an item is at work; a stalled result holds the
// finished item in the controller until the result register frees up.
// ----------------------------------------------------------------------------
module collatz_step_counter #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [clsc_pkg::START_W-1:0]    start_number,
	input  logic                            restart_total,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [clsc_pkg::COUNT_W-1:0]    step_count,
	output logic [clsc_pkg::TOTAL_W-1:0]    total_steps,
	output logic                            overflow
);
	import clsc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing and handshakes
	clsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// value iteration, counting and running total
	clsc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.start_number  (start_number),
		.restart_total (restart_total),
		.step_count    (step_count),
		.total_steps   (total_steps),
		.overflow      (overflow)
	);

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for collatz_step_counter
// Sends starting numbers into the request channel. Each result is checked
// field by field against a shortcut collatz predictor that keeps its own
// running total. The stimulus covers directed edge values, a weighted random
// mix, pauses that drain the block, and a stretch where neither side idles.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import clsc_pkg::*;

	localparam int unsigned VALUE_WIDTH = 64;
	localparam int unsigned IDLE_MAX    = 14;
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned TAIL_CYCLES = 200;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
		logic               ovf;
	} step_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [START_W-1:0] start_number = '0;
	logic               restart_total = 1'b0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [COUNT_W-1:0] step_count;
	logic [TOTAL_W-1:0] total_steps;
	logic               overflow;

	// results still owed by the block, oldest first
	step_result_t       awaited[$];
	// predicted running total of step counts
	logic [TOTAL_W-1:0] tally = '0;

	int unsigned max_gap = IDLE_MAX;
	int unsigned rsp_hold = 0;
	int unsigned fault_count = 0;
	int unsigned results_seen = 0;
	int unsigned items_sent = 0;
	int unsigned overflow_items = 0;
	int unsigned restart_items = 0;
	int unsigned longest_count = 0;

	collatz_step_counter #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.start_number (start_number),
		.restart_total(restart_total),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.step_count   (step_count),
		.total_steps  (total_steps),
		.overflow     (overflow)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// run guard
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("collatz_step_counter test failed");
		$finish;
	end

	// collatz steps down to one via the shortcut map; zero count when the value grows too wide
	function automatic logic [COUNT_W-1:0] shortcut_steps(input logic [START_W-1:0] num,
			output logic ovf);
		logic [START_W-1:0] width_mask;
		logic [START_W-1:0] val;
		logic [START_W-1:0] half;
		logic [63:0]        steps;
		width_mask = (VALUE_WIDTH >= 64) ? {START_W{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
		val = num & width_mask;
		steps = '0;
		ovf = 1'b0;
		while (val > 64'd1 && !ovf) begin
			if (val[0]) begin
				half = val >> 1;
				// (3t+1)/2 = half + t + 1 has to stay inside the value width
				if (half >= width_mask - val) begin
					ovf = 1'b1;
				end else begin
					val = half + val + 64'd1;
					steps += 64'd2;
				end
			end else begin
				val = val >> 1;
				steps += 64'd1;
			end
		end
		if (ovf)
			return '0;
		return (steps > 64'(COUNT_MAX)) ? COUNT_MAX : steps[COUNT_W-1:0];
	endfunction

	// weighted mix of starting numbers
	function automatic logic [START_W-1:0] pick_start_number();
		logic [START_W-1:0] r;
		int unsigned        k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 63);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return r;
			4: return 64'($urandom_range(1, 2000));
			5: return {32'd0, r[31:0]};
			// odd and wide: the first odd step overflows
			6: return {2'b11, r[61:1], 1'b1};
			7: return r >> k;
			// powers of two and all-ones runs, zero now and then
			8: return $urandom_range(0, 1) ? (64'd1 << k) : ((64'd1 << k) - 64'd1);
			default: return {16'd0, r[47:0]};
		endcase
	endfunction

	// send one item and record the result it should give
	task automatic send_number(input logic [START_W-1:0] num, input logic restart);
		int unsigned  gap;
		step_result_t want;
		logic         ovf;
		gap = $urandom_range(0, max_gap);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		start_number <= num;
		restart_total <= restart;
		do @(posedge clk); while (req_stall);

		want.count = shortcut_steps(num, ovf);
		want.ovf = ovf;
		if (restart)
			tally = '0;
		tally += TOTAL_W'(want.count);
		want.total = tally;
		awaited.push_back(want);

		items_sent++;
		if (ovf)
			overflow_items++;
		if (restart)
			restart_items++;
		if (32'(want.count) > longest_count)
			longest_count = 32'(want.count);
	endtask

	// stop sending and wait for every owed result
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
	endtask

	// result checking
	always @(posedge clk) begin : result_check
		step_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (awaited.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: step_count %0d total_steps %0d overflow %0b",
						step_count, total_steps, overflow);
			end else begin
				want = awaited.pop_front();
				if (step_count !== want.count || total_steps !== want.total ||
						overflow !== want.ovf) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"mismatch: step_count %0d/%0d total_steps %0d/%0d ",
							"overflow %0b/%0b (expected/actual)"},
							want.count, step_count, want.total, total_steps,
							want.ovf, overflow);
				end
			end
			rsp_hold = $urandom_range(0, max_gap);
		end
	end

	// receiver stall, drawn after each result
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// edge values: zero, one, short and long trajectories, overflow boundary
	task automatic test_directed_values();
		logic [START_W-1:0] nums [19];
		logic [18:0]        restart_at;
		nums = '{
			64'd27, 64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd97, 64'd871, 64'd63728127,
			64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hAAAA_AAAA_AAAA_AAA9, 64'hAAAA_AAAA_AAAA_AAAB,
			64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h0000_0001_0000_0001, 64'h0000_0000_FFFF_FFFF
		};
		// restart on the zero item, on an overflow item and on one plain item
		restart_at = 19'h1_0402;
		for (int i = 0; i < 19; i++)
			send_number(nums[i], restart_at[i]);
	endtask

	// weighted random numbers with occasional restarts
	task automatic test_random_numbers();
		for (int i = 0; i < 1500; i++)
			send_number(pick_start_number(), $urandom_range(0, 7) == 0);
	endtask

	// groups of items with the block drained in between
	task automatic test_drain_pauses();
		for (int g = 0; g < 10; g++) begin
			for (int i = 0; i < 20; i++)
				send_number(pick_start_number(), $urandom_range(0, 7) == 0);
			wait_drained();
		end
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		max_gap = 0;
		for (int i = 0; i < 230; i++)
			send_number(pick_start_number(), $urandom_range(0, 7) == 0);
		wait_drained();
		max_gap = IDLE_MAX;
	endtask

	// test sequence
	initial begin : run
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_values();
		test_random_numbers();
		test_drain_pauses();
		test_back_to_back();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		fault_count += awaited.size();

		$display("covered %0d items: %0d overflowed, %0d cleared the total, longest count %0d",
			items_sent, overflow_items, restart_items, longest_count);
		$display("checked %0d results, %0d faults", results_seen, fault_count);
		if (fault_count == 0)
			$display("collatz_step_counter test passed");
		else
			$display("collatz_step_counter test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/clsc_pkg.sv
rtl/clsc_dp.sv
rtl/clsc_ctrl.sv
rtl/collatz_step_counter.sv
test/tb.sv
